[hdl/sbus_pkg.sv]
`timescale 1ns / 1ps
package sbus_pkg;

  localparam int ByteW       = 8;
  localparam int PosW        = 5;
  localparam int ChanW       = 11;
  localparam int ChanIdxW    = 4;
  localparam int MaxChannels = 16;
  localparam int FlagW       = 4;
  localparam int CntW        = 32;
  localparam int LineBytes   = 23;
  localparam int LineW       = LineBytes * ByteW;
  localparam int FlagLsb     = 22 * ByteW;
  localparam int OutDataW    = 120;
  localparam int CfgAddrW    = 3;
  localparam int CfgDataW    = 32;
  localparam int NumChannels = 16;

  localparam logic [PosW-1:0]  FrameLast      = 5'd24;
  localparam logic [ByteW-1:0] DefStartMarker = 8'h0F;
  localparam logic [ByteW-1:0] DefEndMarker   = 8'h00;

  localparam logic RegStartMarker = 1'b0;
  localparam logic RegEndMarker   = 1'b1;

  localparam logic KindChan  = 1'b0;
  localparam logic KindError = 1'b1;

  typedef struct packed {
    logic                shift_in;
    logic                finish_good;
    logic                finish_bad;
    logic                emit_chan;
    logic [ChanIdxW-1:0] chan_idx;
    logic                chan_last;
  } sbus_cmd_t;

  typedef struct packed {
    logic start_hit;
    logic end_ok;
    logic out_free;
  } sbus_stat_t;

endpackage

[hdl/sbus_frame_receiver.sv]
`timescale 1ns / 1ps
// channel   dir  handshake                data
// in_       in   in_tvalid/in_tready      in_tdata[7:0] = rx_byte
// out_      out  out_tvalid/out_tready    out_tdata, out_tuser = kind, out_tlast = last
// cfg_      in   APB, pready tied high    0x0 start_marker, 0x4 end_marker
//
// Bytes of a frame are taken one per cycle; a byte that finishes a bad frame
// yields its error item in the next cycle.
// A good frame's end byte yields NUM_CHANNELS items, one per cycle while the output
// is free, from the 11-bit shift of the payload line; no input is taken during that run.
// rst_n is synchronous; after reset the block hunts for the start byte.
// A stalled output holds the item; input still flows unless the next byte ends a frame.
module sbus_frame_receiver #(
  parameter int NUM_CHANNELS = sbus_pkg::NumChannels
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sbus_pkg::ByteW-1:0]      in_tdata,    // [7:0] rx_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [3:0] chan_index, [14:4] chan_value, [15] digital_a, [16] digital_b,
  // [17] lost_flag, [18] failsafe_flag, [50:19] failsafe_count,
  // [82:51] good_frames, [114:83] bad_frames, [119:115] zero
  output logic [sbus_pkg::OutDataW-1:0]   out_tdata,
  output logic                            out_tuser,   // [0] kind
  output logic                            out_tlast,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [sbus_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  logic [sbus_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic [sbus_pkg::CfgDataW-1:0]   cfg_prdata,
  output logic                            cfg_pready
);

  sbus_pkg::sbus_cmd_t  cmd;
  sbus_pkg::sbus_stat_t stat;

  assign cfg_pready = 1'b1;

  sbus_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sbus_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tdata    (in_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

[hdl/sbus_ctrl.sv]
`timescale 1ns / 1ps
module sbus_ctrl #(
  parameter int NUM_CHANNELS = sbus_pkg::NumChannels
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  sbus_pkg::sbus_stat_t stat,
  output sbus_pkg::sbus_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_HUNT = 3'b001,
    ST_FILL = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  localparam logic [sbus_pkg::ChanIdxW-1:0] LastChan =
    sbus_pkg::ChanIdxW'(NUM_CHANNELS - 1);

  state_t                          state_r, state_nxt;
  logic [sbus_pkg::PosW-1:0]       pos_r, pos_nxt;
  logic [sbus_pkg::ChanIdxW-1:0]   ch_r, ch_nxt;
  logic                            acc;
  logic                            last_byte;

  assign acc       = in_tvalid & in_tready;
  assign last_byte = (pos_r == sbus_pkg::FrameLast);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    ch_nxt        = ch_r;
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.chan_idx  = ch_r;
    cmd.chan_last = (ch_r == LastChan);
    case (state_r)
      ST_HUNT: begin
        in_tready = 1'b1;
        if (acc && stat.start_hit) begin
          state_nxt = ST_FILL;
          pos_nxt   = sbus_pkg::PosW'(1);
        end
      end
      ST_FILL: begin
        in_tready = !last_byte || stat.out_free;
        if (acc) begin
          if (!last_byte) begin
            cmd.shift_in = 1'b1;
            pos_nxt      = pos_r + sbus_pkg::PosW'(1);
          end else begin
            pos_nxt = '0;
            if (stat.end_ok) begin
              cmd.finish_good = 1'b1;
              state_nxt       = ST_EMIT;
              ch_nxt          = '0;
            end else begin
              cmd.finish_bad = 1'b1;
              state_nxt      = ST_HUNT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_chan = 1'b1;
          if (ch_r == LastChan) begin
            state_nxt = ST_HUNT;
            ch_nxt    = '0;
          end else begin
            ch_nxt = ch_r + sbus_pkg::ChanIdxW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT;
        pos_nxt   = '0;
        ch_nxt    = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      pos_r   <= '0;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      ch_r    <= ch_nxt;
    end
  end

  a_no_input_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> !in_tready)
    else $error("input ready while emitting channels");

  a_pos_only_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_FILL |-> pos_r == '0)
    else $error("byte position set outside frame fill");

  a_good_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish_good |=> (state_r == ST_EMIT && ch_r == '0))
    else $error("good frame did not start channel emission at channel 0");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_chan || cmd.finish_bad) |-> stat.out_free)
    else $error("result loaded while output register busy");

endmodule

[hdl/sbus_dp.sv]
`timescale 1ns / 1ps
module sbus_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sbus_pkg::sbus_cmd_t                  cmd,
  output sbus_pkg::sbus_stat_t                 stat,
  input  logic [sbus_pkg::ByteW-1:0]           in_tdata,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [sbus_pkg::CfgAddrW-1:0]        cfg_paddr,
  input  logic [sbus_pkg::CfgDataW-1:0]        cfg_pwdata,
  output logic [sbus_pkg::CfgDataW-1:0]        cfg_prdata,
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic [sbus_pkg::OutDataW-1:0]        out_tdata,
  output logic                                 out_tuser,
  output logic                                 out_tlast
);

  localparam int PadW = sbus_pkg::OutDataW - sbus_pkg::ChanIdxW - sbus_pkg::ChanW
                        - sbus_pkg::FlagW - 3 * sbus_pkg::CntW;

  logic [sbus_pkg::ByteW-1:0]    start_r, end_r;
  logic [sbus_pkg::LineW-1:0]    line_r, line_nxt;
  logic [sbus_pkg::FlagW-1:0]    flag_r, flag_nxt;
  logic [sbus_pkg::CntW-1:0]     fs_cnt_r, fs_cnt_nxt;
  logic [sbus_pkg::CntW-1:0]     good_r, good_nxt;
  logic [sbus_pkg::CntW-1:0]     bad_r, bad_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_kind_r, out_kind_nxt;
  logic                          out_last_r, out_last_nxt;
  logic [sbus_pkg::ChanIdxW-1:0] out_idx_r, out_idx_nxt;
  logic [sbus_pkg::ChanW-1:0]    out_val_r, out_val_nxt;
  logic [sbus_pkg::FlagW-1:0]    new_flags;
  logic                          cfg_wr;

  assign cfg_wr    = cfg_psel & cfg_penable & cfg_pwrite;
  assign new_flags = line_r[sbus_pkg::FlagLsb +: sbus_pkg::FlagW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= sbus_pkg::DefStartMarker;
      end_r   <= sbus_pkg::DefEndMarker;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        sbus_pkg::RegStartMarker: start_r <= cfg_pwdata[sbus_pkg::ByteW-1:0];
        sbus_pkg::RegEndMarker:   end_r   <= cfg_pwdata[sbus_pkg::ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      sbus_pkg::RegStartMarker:
        cfg_prdata = {{(sbus_pkg::CfgDataW - sbus_pkg::ByteW){1'b0}}, start_r};
      sbus_pkg::RegEndMarker:
        cfg_prdata = {{(sbus_pkg::CfgDataW - sbus_pkg::ByteW){1'b0}}, end_r};
      default: cfg_prdata = '0;
    endcase
  end

  assign stat.start_hit = (in_tdata == start_r);
  assign stat.end_ok    = (in_tdata == end_r);
  assign stat.out_free  = !out_valid_r || out_tready;

  // frame bytes 1..23 enter at the top; payload ends up LSB-first at bit 0
  always_comb begin
    line_nxt = line_r;
    if (cmd.shift_in) begin
      line_nxt = {in_tdata, line_r[sbus_pkg::LineW-1:sbus_pkg::ByteW]};
    end else if (cmd.emit_chan) begin
      line_nxt = {{sbus_pkg::ChanW{1'b0}}, line_r[sbus_pkg::LineW-1:sbus_pkg::ChanW]};
    end
  end

  always_ff @(posedge clk) begin
    line_r <= line_nxt;
  end

  always_comb begin
    flag_nxt   = flag_r;
    fs_cnt_nxt = fs_cnt_r;
    good_nxt   = good_r;
    bad_nxt    = bad_r;
    if (cmd.finish_good) begin
      flag_nxt = new_flags;
      good_nxt = good_r + sbus_pkg::CntW'(1);
      if (new_flags[3] && !flag_r[3]) begin
        fs_cnt_nxt = fs_cnt_r + sbus_pkg::CntW'(1);
      end
    end
    if (cmd.finish_bad) begin
      bad_nxt = bad_r + sbus_pkg::CntW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    if (cmd.emit_chan) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = sbus_pkg::KindChan;
      out_last_nxt  = cmd.chan_last;
      out_idx_nxt   = cmd.chan_idx;
      out_val_nxt   = line_r[sbus_pkg::ChanW-1:0];
    end else if (cmd.finish_bad) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = sbus_pkg::KindError;
      out_last_nxt  = 1'b1;
      out_idx_nxt   = '0;
      out_val_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r      <= '0;
      fs_cnt_r    <= '0;
      good_r      <= '0;
      bad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      flag_r      <= flag_nxt;
      fs_cnt_r    <= fs_cnt_nxt;
      good_r      <= good_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{PadW{1'b0}}, bad_r, good_r, fs_cnt_r, flag_r, out_val_r, out_idx_r};

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;

  localparam int NumCh = sbus_pkg::NumChannels;
  localparam logic [sbus_pkg::CfgAddrW-1:0] StartAddr =
    sbus_pkg::CfgAddrW'(4 * int'(sbus_pkg::RegStartMarker));
  localparam logic [sbus_pkg::CfgAddrW-1:0] EndAddr =
    sbus_pkg::CfgAddrW'(4 * int'(sbus_pkg::RegEndMarker));

  typedef struct packed {
    logic                          kind;
    logic [sbus_pkg::ChanIdxW-1:0] idx;
    logic [sbus_pkg::ChanW-1:0]    value;
    logic [sbus_pkg::FlagW-1:0]    flags;
    logic [sbus_pkg::CntW-1:0]     fs_count;
    logic [sbus_pkg::CntW-1:0]     good;
    logic [sbus_pkg::CntW-1:0]     bad;
    logic                          is_last;
  } dec_item_t;

  typedef enum int {FillRandom, FillOnes, FillZeros, FillMarker} fill_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [sbus_pkg::ByteW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [sbus_pkg::OutDataW-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [sbus_pkg::CfgAddrW-1:0] cfg_paddr = '0;
  logic [sbus_pkg::CfgDataW-1:0] cfg_pwdata = '0;
  logic [sbus_pkg::CfgDataW-1:0] cfg_prdata;
  logic cfg_pready;

  sbus_frame_receiver #(.NUM_CHANNELS(NumCh)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  // decoder mirror
  logic [sbus_pkg::ByteW-1:0] start_mark = sbus_pkg::DefStartMarker;
  logic [sbus_pkg::ByteW-1:0] end_mark = sbus_pkg::DefEndMarker;
  int                         frame_pos = 0;
  logic [sbus_pkg::ByteW-1:0] frame_buf [24];
  logic [sbus_pkg::FlagW-1:0] flag_state = '0;
  logic [sbus_pkg::CntW-1:0]  fs_events = '0;
  logic [sbus_pkg::CntW-1:0]  ok_frames = '0;
  logic [sbus_pkg::CntW-1:0]  bad_frames = '0;

  logic [sbus_pkg::ByteW-1:0] rx_byte_q [$];
  dec_item_t                  decoded_q [$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int fail_cnt = 0;
  int bytes_sent = 0;
  int items_checked = 0;

  task automatic decode_byte(input logic [sbus_pkg::ByteW-1:0] b);
    logic [22*sbus_pkg::ByteW-1:0] payload;
    logic [sbus_pkg::FlagW-1:0] fl;
    dec_item_t r;
    if (frame_pos == 0) begin
      if (b == start_mark) begin
        frame_buf[0] = b;
        frame_pos = 1;
      end
    end else if (frame_pos < 24) begin
      frame_buf[frame_pos] = b;
      frame_pos++;
    end else begin
      frame_pos = 0;
      if (b != end_mark) begin
        bad_frames++;
        r = '{sbus_pkg::KindError, '0, '0, flag_state, fs_events, ok_frames,
              bad_frames, 1'b1};
        decoded_q.push_back(r);
      end else begin
        for (int i = 0; i < 22; i++)
          payload[sbus_pkg::ByteW*i +: sbus_pkg::ByteW] = frame_buf[i+1];
        fl = frame_buf[23][sbus_pkg::FlagW-1:0];
        if (fl[3] && !flag_state[3]) fs_events++;
        flag_state = fl;
        ok_frames++;
        for (int i = 0; i < NumCh; i++) begin
          r = '{sbus_pkg::KindChan, sbus_pkg::ChanIdxW'(i),
                payload[sbus_pkg::ChanW*i +: sbus_pkg::ChanW], flag_state,
                fs_events, ok_frames, bad_frames, (i == NumCh - 1)};
          decoded_q.push_back(r);
        end
      end
    end
  endtask

  task automatic compare(input string what, input logic [31:0] exp, input logic [31:0] act);
    if (act !== exp) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("mismatch %s: expected %0h, got %0h", what, exp, act);
    end
  endtask

  task automatic check_item();
    dec_item_t e;
    if (decoded_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("unexpected item: tuser %0h tdata %0h", out_tuser, out_tdata);
    end else begin
      e = decoded_q.pop_front();
      items_checked++;
      compare("kind", e.kind, out_tuser);
      compare("chan_index", e.idx, out_tdata[3:0]);
      compare("chan_value", e.value, out_tdata[14:4]);
      compare("flags", e.flags, out_tdata[18:15]);
      compare("failsafe_count", e.fs_count, out_tdata[50:19]);
      compare("good_frames", e.good, out_tdata[82:51]);
      compare("bad_frames", e.bad, out_tdata[114:83]);
      compare("pad", '0, out_tdata[119:115]);
      compare("last", e.is_last, out_tlast);
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!in_tvalid || in_tready) begin
      if (rst_n && rx_byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= rx_byte_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata);
        bytes_sent++;
      end
      if (out_tvalid && out_tready) check_item();
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic cfg_set(input logic [sbus_pkg::CfgAddrW-1:0] addr,
                         input logic [sbus_pkg::ByteW-1:0] val);
    logic [sbus_pkg::CfgDataW-1:0] w;
    w = $urandom();
    w[sbus_pkg::ByteW-1:0] = val;
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= w;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == StartAddr) start_mark = val;
    else end_mark = val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    compare("register readback", val, cfg_prdata[sbus_pkg::ByteW-1:0]);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic queue_noise(input int n);
    logic [sbus_pkg::ByteW-1:0] b;
    for (int i = 0; i < n; i++) begin
      b = sbus_pkg::ByteW'($urandom_range(255));
      if (b == start_mark) b = b + 1'b1;
      rx_byte_q.push_back(b);
    end
  endtask

  task automatic queue_frame(input fill_t fill, input logic [sbus_pkg::ByteW-1:0] flag_byte,
                             input bit good_end);
    logic [sbus_pkg::ByteW-1:0] b;
    rx_byte_q.push_back(start_mark);
    for (int i = 0; i < 22; i++) begin
      case (fill)
        FillOnes: b = 8'hFF;
        FillZeros: b = 8'h00;
        FillMarker: b = (i % 2 == 0) ? start_mark : sbus_pkg::ByteW'($urandom_range(255));
        default: b = sbus_pkg::ByteW'($urandom_range(255));
      endcase
      rx_byte_q.push_back(b);
    end
    rx_byte_q.push_back(flag_byte);
    b = sbus_pkg::ByteW'($urandom_range(255));
    if (b == end_mark) b = b + 1'b1;
    rx_byte_q.push_back(good_end ? end_mark : b);
  endtask

  task automatic wait_drained();
    while (rx_byte_q.size() != 0 || in_tvalid || decoded_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    #200000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
          cfg_set(StartAddr, sbus_pkg::DefStartMarker);
          cfg_set(EndAddr, sbus_pkg::DefEndMarker);
          // noise while hunting, all-ones frame with failsafe edge
          rx_byte_q.push_back(8'h00);
          rx_byte_q.push_back(8'hFF);
          rx_byte_q.push_back(8'h0E);
          rx_byte_q.push_back(8'h10);
          queue_frame(FillOnes, 8'hFF, 1'b1);
        end
        1: begin
          send_idle_pct = 64;
          stall_pct = 0;
          cfg_set(StartAddr, 8'h00);
          cfg_set(EndAddr, 8'hFF);
          // bad frame with start bytes inside
          queue_noise($urandom_range(0, 3));
          queue_frame(FillMarker, 8'h08, 1'b0);
          // hold the sender until all results are back
          wait_drained();
          queue_frame(FillRandom, sbus_pkg::ByteW'($urandom_range(255)),
                      $urandom_range(99) >= 15);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 64;
          cfg_set(StartAddr, 8'hFF);
          cfg_set(EndAddr, 8'h00);
          queue_noise($urandom_range(0, 3));
          queue_frame(FillZeros, 8'h00, 1'b1);
        end
        default: begin
          send_idle_pct = 15;
          stall_pct = 15;
          cfg_set(StartAddr, sbus_pkg::ByteW'($urandom_range(255)));
          cfg_set(EndAddr, sbus_pkg::ByteW'($urandom_range(255)));
          queue_noise($urandom_range(0, 3));
          queue_frame(FillRandom, sbus_pkg::ByteW'($urandom_range(255)),
                      $urandom_range(99) >= 15);
        end
      endcase
      wait_drained();
    end
    $display("%0d bytes sent, %0d good and %0d bad frames, %0d items checked",
             bytes_sent, ok_frames, bad_frames, items_checked);
    $display("marker settings default, 00/FF, FF/00 and random; four idle and stall mixes");
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
